FILE: hdl/olae_pkg.sv
// Shared types and codes for the ordered array list engine.
// No dependencies.
package olae_pkg;

  localparam int WORD_W = 32;

  // command codes
  localparam logic [3:0] CMD_INS_TAIL    = 4'd0;
  localparam logic [3:0] CMD_INS_HEAD    = 4'd1;
  localparam logic [3:0] CMD_INS_SORTED  = 4'd2;
  localparam logic [3:0] CMD_REM_TAIL    = 4'd3;
  localparam logic [3:0] CMD_REM_HEAD    = 4'd4;
  localparam logic [3:0] CMD_REM_VALUE   = 4'd5;
  localparam logic [3:0] CMD_FIND_LINEAR = 4'd6;
  localparam logic [3:0] CMD_FIND_SORTED = 4'd7;
  localparam logic [3:0] CMD_SORT        = 4'd8;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_TOO_FEW   = 3'd4;

  // sift modes: when a stored word moves up past the word being placed
  localparam logic [1:0] SM_NEVER  = 2'd0;
  localparam logic [1:0] SM_ALWAYS = 2'd1;
  localparam logic [1:0] SM_GT     = 2'd2;
  localparam logic [1:0] SM_LT     = 2'd3;

  typedef struct packed {
    logic move;   // stored word moves past the operand
    logic equal;  // stored word equals the operand
  } cmp_res_t;

endpackage

FILE: hdl/ordered_array_list_engine.sv
// Top level: command sequencer over one entry RAM and one shared compare unit.
// Depends on olae_pkg, olae_ram, olae_cmp.
//
//  channel  | handshake          | words
//  ---------+--------------------+-------------------------------------------------
//  command  | start, busy        | command, value, descending
//  result   | done (1-cycle)     | status, removed_value, found, entry_count
//
// One command at a time; busy stays high until the result strobe has gone.
// Sorted insert and sorted find run a full sort first when more than one entry
// is held. Every sift and scan step goes through the one RAM read port with its
// registered read.
// Reset clears the count; the entry RAM is not cleared.
// The result cannot be stalled: it shows for the single cycle that done is high.
module ordered_array_list_engine
  import olae_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [3:0]               command,
  input  logic signed [WORD_W-1:0] value,
  input  logic                     descending,
  output logic                     done,
  output logic [2:0]               status,
  output logic signed [WORD_W-1:0] removed_value,
  output logic                     found,
  output logic [7:0]               entry_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SORT_RD  = 4'd1;
  localparam logic [3:0] S_SORT_LD  = 4'd2;
  localparam logic [3:0] S_SIFT_RD  = 4'd3;
  localparam logic [3:0] S_SIFT_CMP = 4'd4;
  localparam logic [3:0] S_SCAN_RD  = 4'd5;
  localparam logic [3:0] S_SCAN_CMP = 4'd6;
  localparam logic [3:0] S_SHIFT_RD = 4'd7;
  localparam logic [3:0] S_SHIFT_WR = 4'd8;
  localparam logic [3:0] S_TAIL_RD  = 4'd9;
  localparam logic [3:0] S_TAIL_CAP = 4'd10;
  localparam logic [3:0] S_DONE     = 4'd11;

  logic [3:0]               state;
  logic [3:0]               cmd;
  logic signed [WORD_W-1:0] val;
  logic signed [WORD_W-1:0] cur;
  logic [CW-1:0]            i;
  logic [CW-1:0]            j;
  logic [CW-1:0]            count;
  logic [1:0]               mode;
  logic                     sift_ins;
  logic [2:0]               status_q;
  logic signed [WORD_W-1:0] removed_q;
  logic                     found_q;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [WORD_W-1:0]        ram_wdata;
  logic [AW-1:0]            ram_raddr;
  logic [WORD_W-1:0]        ram_rdata;

  logic signed [WORD_W-1:0] cmp_operand;
  cmp_res_t                 cmp_res;

  logic [CW-1:0]            ip1;
  logic [CW-1:0]            jm1;
  logic [CW-1:0]            cm1;
  logic                     sift_fin;
  logic [CW+7:0]            count_ext;

  assign ip1 = i + ONE_C;
  assign jm1 = j - ONE_C;
  assign cm1 = count - ONE_C;

  assign sift_fin = ((state == S_SIFT_RD) && ((j == '0) || (mode == SM_NEVER))) ||
                    ((state == S_SIFT_CMP) && !cmp_res.move);

  assign cmp_operand = (state == S_SCAN_CMP) ? val : cur;

  olae_cmp u_cmp (
    .stored  ($signed(ram_rdata)),
    .operand (cmp_operand),
    .mode    (mode),
    .res     (cmp_res)
  );

  olae_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = j[AW-1:0];
    ram_wdata = cur;
    ram_raddr = '0;
    case (state)
      S_SORT_RD: ram_raddr = i[AW-1:0];
      S_SIFT_RD: begin
        ram_raddr = jm1[AW-1:0];
        ram_we    = sift_fin;
      end
      S_SIFT_CMP: begin
        ram_we    = 1'b1;
        ram_wdata = cmp_res.move ? ram_rdata : cur;
      end
      S_SCAN_RD:  ram_raddr = i[AW-1:0];
      S_SHIFT_RD: ram_raddr = ip1[AW-1:0];
      S_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = i[AW-1:0];
        ram_wdata = ram_rdata;
      end
      S_TAIL_RD:  ram_raddr = cm1[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      mode     <= SM_NEVER;
      sift_ins <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd       <= command;
            val       <= value;
            status_q  <= ST_OK;
            removed_q <= '0;
            found_q   <= 1'b0;
            i         <= ONE_C;
            state     <= S_DONE;
            case (command)
              CMD_INS_TAIL, CMD_INS_HEAD, CMD_INS_SORTED: begin
                if (count >= CAP_C) begin
                  status_q <= ST_FULL;
                end else if ((command == CMD_INS_SORTED) && (count > ONE_C)) begin
                  mode     <= SM_GT;
                  sift_ins <= 1'b0;
                  state    <= S_SORT_RD;
                end else begin
                  cur      <= value;
                  j        <= count;
                  sift_ins <= 1'b1;
                  case (command)
                    CMD_INS_TAIL: mode <= SM_NEVER;
                    CMD_INS_HEAD: mode <= SM_ALWAYS;
                    default:      mode <= SM_GT;
                  endcase
                  state <= S_SIFT_RD;
                end
              end
              CMD_REM_TAIL, CMD_REM_HEAD, CMD_REM_VALUE, CMD_FIND_LINEAR: begin
                if (count == '0) begin
                  status_q <= ST_EMPTY;
                end else if (command == CMD_REM_TAIL) begin
                  state <= S_TAIL_RD;
                end else begin
                  i     <= '0;
                  state <= S_SCAN_RD;
                end
              end
              CMD_FIND_SORTED: begin
                if (count == '0) begin
                  status_q <= ST_EMPTY;
                end else if (count > ONE_C) begin
                  mode     <= SM_GT;
                  sift_ins <= 1'b0;
                  state    <= S_SORT_RD;
                end else begin
                  i     <= '0;
                  state <= S_SCAN_RD;
                end
              end
              CMD_SORT: begin
                if (count == '0) begin
                  status_q <= ST_EMPTY;
                end else if (count == ONE_C) begin
                  status_q <= ST_TOO_FEW;
                end else begin
                  mode     <= descending ? SM_LT : SM_GT;
                  sift_ins <= 1'b0;
                  state    <= S_SORT_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_SORT_RD: state <= S_SORT_LD;
        S_SORT_LD: begin
          cur   <= $signed(ram_rdata);
          j     <= i;
          state <= S_SIFT_RD;
        end
        S_SIFT_RD: begin
          if (!sift_fin) begin
            state <= S_SIFT_CMP;
          end
        end
        S_SIFT_CMP: begin
          if (!sift_fin) begin
            j     <= jm1;
            state <= S_SIFT_RD;
          end
        end
        S_SCAN_RD: begin
          if (i == count) begin
            status_q <= ST_NOT_FOUND;
            state    <= S_DONE;
          end else begin
            state <= S_SCAN_CMP;
          end
        end
        S_SCAN_CMP: begin
          // remove head takes the first word whatever its value
          if ((cmd == CMD_REM_HEAD) || cmp_res.equal) begin
            if ((cmd == CMD_REM_HEAD) || (cmd == CMD_REM_VALUE)) begin
              removed_q <= $signed(ram_rdata);
              state     <= S_SHIFT_RD;
            end else begin
              found_q <= 1'b1;
              state   <= S_DONE;
            end
          end else begin
            i     <= ip1;
            state <= S_SCAN_RD;
          end
        end
        S_SHIFT_RD: begin
          if (ip1 >= count) begin
            count <= cm1;
            state <= S_DONE;
          end else begin
            state <= S_SHIFT_WR;
          end
        end
        S_SHIFT_WR: begin
          i     <= ip1;
          state <= S_SHIFT_RD;
        end
        S_TAIL_RD: state <= S_TAIL_CAP;
        S_TAIL_CAP: begin
          removed_q <= $signed(ram_rdata);
          count     <= cm1;
          state     <= S_DONE;
        end
        S_DONE:  state <= S_IDLE;
        default: state <= S_IDLE;
      endcase

      // end of one sift: an insert completes, or the sort moves on to its next word or ends
      if (sift_fin) begin
        if (sift_ins) begin
          count <= count + ONE_C;
          state <= S_DONE;
        end else if (ip1 == count) begin
          if (cmd == CMD_INS_SORTED) begin
            cur      <= val;
            j        <= count;
            mode     <= SM_GT;
            sift_ins <= 1'b1;
            state    <= S_SIFT_RD;
          end else if (cmd == CMD_FIND_SORTED) begin
            i     <= '0;
            state <= S_SCAN_RD;
          end else begin
            state <= S_DONE;
          end
        end else begin
          i     <= ip1;
          state <= S_SORT_RD;
        end
      end
    end
  end

  assign count_ext     = {8'd0, count};
  assign busy          = (state != S_IDLE);
  assign done          = (state == S_DONE);
  assign status        = status_q;
  assign removed_value = removed_q;
  assign found         = found_q;
  assign entry_count   = count_ext[7:0];

endmodule

FILE: hdl/olae_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module olae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/olae_cmp.sv
// Shared signed compare unit used by every sift and scan step.
// Depends on olae_pkg.
module olae_cmp
  import olae_pkg::*;
(
  input  logic signed [WORD_W-1:0] stored,
  input  logic signed [WORD_W-1:0] operand,
  input  logic [1:0]               mode,
  output cmp_res_t                 res
);

  always_comb begin
    res.equal = (stored == operand);
    case (mode)
      SM_NEVER:  res.move = 1'b0;
      SM_ALWAYS: res.move = 1'b1;
      SM_GT:     res.move = (stored > operand);
      SM_LT:     res.move = (stored < operand);
      default:   res.move = 1'b0;
    endcase
  end

endmodule

FILE: hdl/olae_chk.sv
// Port-level checker for the ordered array list engine, bound to the top level.
// Depends on olae_pkg.
module olae_chk
  import olae_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic                     busy,
  input logic [3:0]               command,
  input logic signed [WORD_W-1:0] value,
  input logic                     descending,
  input logic                     done,
  input logic [2:0]               status,
  input logic signed [WORD_W-1:0] removed_value,
  input logic                     found,
  input logic [7:0]               entry_count
);

  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_strobe_single : assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_empty_count : assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_EMPTY)) |-> (entry_count == 8'd0))
    else $error("empty status with entries held");

  a_found_ok : assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> (status == ST_OK))
    else $error("found flag without ok status");

  a_removed_ok : assert property (@(posedge clk) disable iff (rst)
    (done && (removed_value != '0)) |-> (status == ST_OK))
    else $error("removed word reported on a failed command");

endmodule

bind ordered_array_list_engine olae_chk u_olae_chk (.*);

FILE: bench/ordered_array_list_engine_tb.sv
// Self-checking bench for ordered_array_list_engine: a shadow list predicts every
// command's result word, and each done strobe is compared against the oldest prediction.
// Depends on olae_pkg and the ordered_array_list_engine RTL.
module ordered_array_list_engine_tb;
  import olae_pkg::*;

  localparam int CAPACITY = 128;

  typedef struct {
    logic [2:0]               status;
    logic signed [WORD_W-1:0] removed_value;
    logic                     found;
    logic [7:0]               entry_count;
  } list_result_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [3:0]               command;
  logic signed [WORD_W-1:0] value;
  logic                     descending;
  logic                     done;
  logic [2:0]               status;
  logic signed [WORD_W-1:0] removed_value;
  logic                     found;
  logic [7:0]               entry_count;

  logic signed [WORD_W-1:0] list_words[$];   // shadow of the stored list, head first
  list_result_t             expected_results[$];
  int                       fail_count = 0;

  ordered_array_list_engine #(.CAPACITY(CAPACITY)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .value(value), .descending(descending),
    .done(done), .status(status), .removed_value(removed_value),
    .found(found), .entry_count(entry_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // worst case is a full reverse sort on every word plus the longest gaps
  initial begin
    #1000000000;
    $display("tb: failure");
    $finish;
  end

  // insertion sort of the shadow list; ascending unless desc
  function automatic void order_words(input logic desc);
    logic signed [WORD_W-1:0] cur;
    int j;
    for (int i = 1; i < list_words.size(); i++) begin
      cur = list_words[i];
      j = i;
      while (j > 0 && (desc ? list_words[j-1] < cur : list_words[j-1] > cur)) begin
        list_words[j] = list_words[j-1];
        j--;
      end
      list_words[j] = cur;
    end
  endfunction

  function automatic int first_equal(input logic signed [WORD_W-1:0] val);
    int idx;
    idx = -1;
    for (int i = 0; i < list_words.size() && idx < 0; i++)
      if (list_words[i] == val) idx = i;
    return idx;
  endfunction

  // applies one command to the shadow list and queues the result word it yields
  task automatic predict_list_command(input logic [3:0] cmd,
                                      input logic signed [WORD_W-1:0] val,
                                      input logic desc);
    list_result_t r;
    int pos;
    r.status        = ST_OK;
    r.removed_value = '0;
    r.found         = 1'b0;
    case (cmd)
      CMD_INS_TAIL, CMD_INS_HEAD, CMD_INS_SORTED: begin
        if (list_words.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (cmd == CMD_INS_TAIL) begin
          list_words.push_back(val);
        end else if (cmd == CMD_INS_HEAD) begin
          list_words.push_front(val);
        end else begin
          order_words(1'b0);
          pos = list_words.size();
          for (int i = 0; i < list_words.size() && pos == list_words.size(); i++)
            if (list_words[i] > val) pos = i;
          list_words.insert(pos, val);
        end
      end
      CMD_REM_TAIL, CMD_REM_HEAD, CMD_REM_VALUE: begin
        if (list_words.size() == 0) begin
          r.status = ST_EMPTY;
        end else if (cmd == CMD_REM_TAIL) begin
          r.removed_value = list_words.pop_back();
        end else if (cmd == CMD_REM_HEAD) begin
          r.removed_value = list_words.pop_front();
        end else begin
          pos = first_equal(val);
          if (pos < 0) begin
            r.status = ST_NOT_FOUND;
          end else begin
            list_words.delete(pos);
            r.removed_value = val;
          end
        end
      end
      CMD_FIND_LINEAR, CMD_FIND_SORTED: begin
        if (list_words.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // a sorted find sorts first and then scans, so it finds exactly what a scan finds
          if (cmd == CMD_FIND_SORTED) order_words(1'b0);
          r.found  = (first_equal(val) >= 0);
          r.status = r.found ? ST_OK : ST_NOT_FOUND;
        end
      end
      CMD_SORT: begin
        if (list_words.size() == 0) r.status = ST_EMPTY;
        else if (list_words.size() == 1) r.status = ST_TOO_FEW;
        else order_words(desc);
      end
      default: ;  // unused codes leave the list alone
    endcase
    r.entry_count = 8'(list_words.size());
    expected_results.push_back(r);
  endtask

  // holds start high with the word until the engine takes it
  task automatic send_word(input logic [3:0] cmd, input logic signed [WORD_W-1:0] val,
                           input logic desc);
    @(negedge clk);
    start      <= 1'b1;
    command    <= cmd;
    value      <= val;
    descending <= desc;
    do @(posedge clk); while (busy !== 1'b0);
    predict_list_command(cmd, val, desc);
  endtask

  task automatic sender_gap(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_results
    list_result_t want;
    if (rst === 1'b0 && done === 1'b1) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("result word with nothing expected at %0t", $time);
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status || removed_value !== want.removed_value ||
            found !== want.found || entry_count !== want.entry_count) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch at %0t: status %0d/%0d removed %0d/%0d found %0d/%0d count %0d/%0d",
                     $time, want.status, status, want.removed_value, removed_value,
                     want.found, found, want.entry_count, entry_count);
        end
      end
    end
  end

  function automatic logic signed [WORD_W-1:0] pick_value();
    int unsigned r;
    int near_zero;
    r = $urandom_range(0, 99);
    if (r < 35 && list_words.size() > 0)
      return list_words[$urandom_range(0, list_words.size() - 1)];
    if (r < 65) begin
      near_zero = $urandom_range(0, 16);
      return near_zero - 8;
    end
    if (r < 90) return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return -1;
      default: return 0;
    endcase
  endfunction

  // command mix leans toward inserts below the target size, removes above it
  function automatic logic [3:0] pick_command(input int target);
    int unsigned r;
    logic [3:0] cmd;
    r = $urandom_range(0, 99);
    if (r < 3) return CMD_SORT + 4'($urandom_range(1, 7));
    if (list_words.size() < target) begin
      if (r < 23)      cmd = CMD_INS_TAIL;
      else if (r < 38) cmd = CMD_INS_HEAD;
      else if (r < 58) cmd = CMD_INS_SORTED;
      else if (r < 63) cmd = CMD_REM_TAIL;
      else if (r < 68) cmd = CMD_REM_HEAD;
      else if (r < 75) cmd = CMD_REM_VALUE;
      else if (r < 85) cmd = CMD_FIND_LINEAR;
      else if (r < 93) cmd = CMD_FIND_SORTED;
      else             cmd = CMD_SORT;
    end else begin
      if (r < 10)      cmd = CMD_INS_TAIL;
      else if (r < 15) cmd = CMD_INS_HEAD;
      else if (r < 22) cmd = CMD_INS_SORTED;
      else if (r < 37) cmd = CMD_REM_TAIL;
      else if (r < 52) cmd = CMD_REM_HEAD;
      else if (r < 72) cmd = CMD_REM_VALUE;
      else if (r < 82) cmd = CMD_FIND_LINEAR;
      else if (r < 90) cmd = CMD_FIND_SORTED;
      else             cmd = CMD_SORT;
    end
    // full sorts of a long list are slow; keep them rare
    if (cmd == CMD_SORT && list_words.size() > 32 && $urandom_range(0, 9) != 0)
      cmd = CMD_FIND_LINEAR;
    return cmd;
  endfunction

  task automatic run_traffic(input int n_words, input int idle_pct, input logic fill);
    int target;
    target = fill ? CAPACITY : $urandom_range(0, 20);
    for (int k = 0; k < n_words; k++) begin
      if (!fill && $urandom_range(0, 99) < 5) target = $urandom_range(0, 20);
      send_word(pick_command(target), pick_value(), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 99) < idle_pct)
        sender_gap($urandom_range(1, 2 * list_words.size() + 16));
    end
    wait_all_results();
  endtask

  task automatic test_empty_list();
    send_word(CMD_REM_TAIL, 0, 1'b0);
    send_word(CMD_REM_HEAD, 0, 1'b0);
    send_word(CMD_REM_VALUE, 5, 1'b0);
    send_word(CMD_FIND_LINEAR, 0, 1'b0);
    send_word(CMD_FIND_SORTED, 0, 1'b0);
    send_word(CMD_SORT, 0, 1'b1);
  endtask

  task automatic test_single_entry();
    send_word(CMD_INS_SORTED, 7, 1'b1);   // sorted insert into an empty list
    send_word(CMD_SORT, 0, 1'b0);         // too few to sort
    send_word(CMD_FIND_SORTED, 7, 1'b0);
    send_word(CMD_FIND_SORTED, 8, 1'b0);
  endtask

  task automatic test_inserts_and_order();
    send_word(CMD_INS_HEAD, 32'sh8000_0000, 1'b1);
    send_word(CMD_INS_TAIL, 32'sh7FFF_FFFF, 1'b0);
    send_word(CMD_INS_SORTED, -100, 1'b0);
    send_word(CMD_INS_SORTED, 32'sh8000_0000, 1'b1);  // ties with the smallest word
    send_word(CMD_INS_TAIL, -1, 1'b0);
    send_word(CMD_INS_HEAD, 0, 1'b0);
    send_word(CMD_SORT, 0, 1'b1);
    send_word(CMD_INS_SORTED, 32'sh8000_0001, 1'b0);
    send_word(CMD_SORT, 0, 1'b0);
  endtask

  task automatic test_searches();
    send_word(CMD_FIND_LINEAR, -1, 1'b1);
    send_word(CMD_FIND_LINEAR, 12345, 1'b0);
    send_word(CMD_FIND_SORTED, 32'sh7FFF_FFFF, 1'b0);
    send_word(CMD_FIND_SORTED, 3, 1'b1);
  endtask

  task automatic test_removals();
    send_word(CMD_REM_VALUE, -100, 1'b0);
    send_word(CMD_REM_VALUE, 99, 1'b0);
    send_word(CMD_REM_HEAD, 0, 1'b1);
    send_word(CMD_REM_TAIL, 0, 1'b0);
  endtask

  task automatic test_unused_codes();
    send_word(CMD_SORT + 4'd1, -1, 1'b1);
    send_word(CMD_SORT + 4'd7, 32'sh7FFF_FFFF, 1'b0);
    wait_all_results();
  endtask

  task automatic test_random_traffic();
    run_traffic(300, 0, 1'b0);
    run_traffic(300, 48, 1'b0);
    run_traffic(500, 0, 1'b1);    // climbs to capacity and keeps hitting the full case
    run_traffic(400, 21, 1'b0);   // drains back toward small lists
  endtask

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    command    = CMD_INS_TAIL;
    value      = '0;
    descending = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_list();
    test_single_entry();
    test_inserts_and_order();
    test_searches();
    test_removals();
    test_unused_codes();
    test_random_traffic();

    wait_all_results();
    repeat (4 * CAPACITY) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: ordered_array_list_engine.f
hdl/olae_pkg.sv
hdl/olae_ram.sv
hdl/olae_cmp.sv
hdl/ordered_array_list_engine.sv
hdl/olae_chk.sv
bench/ordered_array_list_engine_tb.sv
